@@ sv/hex_ascii_read_reply_parser_defines.svh @@
// Assertion macros shared by the read-reply parser RTL.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef HEX_ASCII_READ_REPLY_PARSER_DEFINES_SVH
`define HEX_ASCII_READ_REPLY_PARSER_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define HEXRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Invariant checked at every clock edge outside reset
`define HEXRD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

@@ sv/hexrd_pkg.sv @@
// Shared types, codes and the hex digit decoder of the read-reply parser.
// No dependencies; imported by every module of the block but hexrd_buf.
package hexrd_pkg;

  // Framing characters
  localparam logic [7:0] STX_CHAR = 8'h02;
  localparam logic [7:0] ETX_CHAR = 8'h03;
  localparam logic [7:0] ERR_CHAR = 8'h0F;

  // Hex digit ranges
  localparam logic [7:0] DIG_LO   = 8'h30;
  localparam logic [7:0] DIG_HI   = 8'h39;
  localparam logic [7:0] UPPER_LO = 8'h41;
  localparam logic [7:0] UPPER_HI = 8'h46;
  localparam logic [7:0] LOWER_LO = 8'h61;
  localparam logic [7:0] LOWER_HI = 8'h66;
  // 'A' and 'a' have low nibble 1 and stand for 10
  localparam logic [3:0] ALPHA_ADJ = 4'd9;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_WORD_COUNT    = 2'd0;
  localparam logic [1:0] REG_START_ADDRESS = 2'd1;
  localparam logic [1:0] REG_DATA_TYPE     = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_WORD      = 2'd0;
  localparam logic [1:0] ST_DEV_ERR   = 2'd1;
  localparam logic [1:0] ST_BAD_FRAME = 2'd2;

  // Work handed from the front end to the result sequencer
  typedef enum logic [1:0] {
    CMD_ERR_REPLY,
    CMD_BAD_FRAME,
    CMD_WORDS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      bank;   // buffer bank holding the decoded words
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SEND
  } back_state_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_dig_t;

  // ASCII hex character to nibble; bad set (and value 0) for anything else
  function automatic hex_dig_t hex_decode(input logic [7:0] c);
    hex_dig_t d;
    d.bad = 1'b0;
    d.val = 4'h0;
    if (c inside {[DIG_LO:DIG_HI]}) begin
      d.val = c[3:0];
    end else if (c inside {[UPPER_LO:UPPER_HI], [LOWER_LO:LOWER_HI]}) begin
      d.val = c[3:0] + ALPHA_ADJ;
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

@@ sv/hex_ascii_read_reply_parser.sv @@
// Top level of the STX/ETX ASCII-hex read-reply parser: config registers and wiring.
// Uses hexrd_pkg, hexrd_front, hexrd_queue, hexrd_buf and hexrd_back.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+------------------------------------------
//   rx       | rx_valid / rx_stall            | rx_byte
//   out      | out_valid / out_stall          | word_value word_address type_tag status last
//   config   | psel penable pwrite pready     | paddr pwdata / prdata
//
// A received byte is taken while rx_stall is low; the front end stalls only while the
// two-entry command queue is full. A word reply picks up its command and reads the
// first word, then per beat loads the output register from the buffer read and
// sends it, reading the next word as it goes; an error result is loaded, then sent.
// Reset clears the frame tracker, queue and sequencer; config returns to
// word_count 1, start_address 0, data_type 0. No clearing pass is needed.
module hex_ascii_read_reply_parser #(
  parameter int MAX_WORDS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rx_valid,
  output logic                           rx_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    word_value,
  output logic [15:0]                    word_address,
  output logic [7:0]                     type_tag,
  output logic [1:0]                     status,
  output logic                           last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hexrd_pkg::ADDR_W-1:0]   paddr,
  input  logic [hexrd_pkg::DATA_W-1:0]   pwdata,
  output logic [hexrd_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);
  import hexrd_pkg::*;

  localparam int NW     = $clog2(MAX_WORDS + 1);
  localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [4:0]        word_count;
  logic [15:0]       start_address;
  logic [7:0]        data_type;
  logic              cfg_wr;
  logic [1:0]        reg_sel;
  logic [NW-1:0]     n_use;
  logic              q_full, push, pop, head_valid;
  cmd_t              push_cmd, head_cmd;
  logic              wr_en, wr_lane, rd_en;
  logic [WIDX_W:0]   wr_addr, rd_addr;
  logic [7:0]        wr_data;
  logic [15:0]       rd_data;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= 5'd1;
      start_address <= 16'h0000;
      data_type     <= 8'h00;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WORD_COUNT:    word_count    <= pwdata[4:0];
        REG_START_ADDRESS: start_address <= pwdata[15:0];
        REG_DATA_TYPE:     data_type     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WORD_COUNT:    prdata = DATA_W'(word_count);
      REG_START_ADDRESS: prdata = DATA_W'(start_address);
      REG_DATA_TYPE:     prdata = DATA_W'(data_type);
      default:           prdata = '0;
    endcase
  end

  // word count in use: zero reads as one, clamp to buffer size
  always_comb begin
    if (word_count == 5'd0) begin
      n_use = NW'(1);
    end else if (int'(word_count) > MAX_WORDS) begin
      n_use = NW'(MAX_WORDS);
    end else begin
      n_use = NW'(word_count);
    end
  end

  hexrd_front #(.MAX_WORDS(MAX_WORDS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_stall (rx_stall),
    .n_use    (n_use),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_lane  (wr_lane),
    .wr_data  (wr_data)
  );

  hexrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  hexrd_buf #(.MAX_WORDS(MAX_WORDS)) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_lane (wr_lane),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hexrd_back #(.MAX_WORDS(MAX_WORDS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .n_use         (n_use),
    .start_address (start_address),
    .data_type     (data_type),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .word_value    (word_value),
    .word_address  (word_address),
    .type_tag      (type_tag),
    .status        (status),
    .last          (last)
  );

endmodule

@@ sv/hexrd_buf.sv @@
// Decoded word buffer: two banks of 2**WIDX_W 16-bit words, byte-lane writes.
// Uses nothing from the package; one write and one registered read per cycle.
module hexrd_buf #(
  parameter  int MAX_WORDS = 16,
  localparam int WIDX_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [WIDX_W:0]   wr_addr,
  input  logic              wr_lane,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [WIDX_W:0]   rd_addr,
  output logic [15:0]       rd_data
);

  localparam int DEPTH = 2 ** (WIDX_W + 1);

  logic [15:0] mem [DEPTH];

  // byte write: lane 0 is the low half (first byte of a word)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_lane) begin
        mem[wr_addr][15:8] <= wr_data;
      end else begin
        mem[wr_addr][7:0] <= wr_data;
      end
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/hexrd_front.sv @@
// Front end: takes received bytes, tracks the frame and decodes hex pairs.
// Uses hexrd_pkg; writes hexrd_buf and pushes one command per frame outcome.
`include "hex_ascii_read_reply_parser_defines.svh"

module hexrd_front #(
  parameter  int MAX_WORDS = 16,
  localparam int NW        = $clog2(MAX_WORDS + 1),
  localparam int WIDX_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  input  logic [7:0]        rx_byte,
  output logic              rx_stall,
  input  logic [NW-1:0]     n_use,
  input  logic              q_full,
  output logic              push,
  output hexrd_pkg::cmd_t   push_cmd,
  output logic              wr_en,
  output logic [WIDX_W:0]   wr_addr,
  output logic              wr_lane,
  output logic [7:0]        wr_data
);
  import hexrd_pkg::*;

  localparam int PW = $clog2(4 * MAX_WORDS + 4);

  logic [PW-1:0] pos, pos_next;
  logic [3:0]    high_nibble, high_nibble_next;
  logic          digit_fault, digit_fault_next;
  logic          etx_seen, etx_seen_next;
  logic          bank, bank_next;
  logic          accept;
  logic [PW:0]   idx, four_n, lim, pos_inc;
  hex_dig_t      dig;

  // a byte may push a command, so every byte is held off while the queue is full
  assign rx_stall = q_full;
  assign accept   = rx_valid && !rx_stall;

  // frame tracking and decode
  always_comb begin
    dig              = hex_decode(rx_byte);
    four_n           = (PW + 1)'({n_use, 2'b00});
    lim              = four_n + (PW + 1)'(4);
    pos_inc          = (PW + 1)'(pos) + (PW + 1)'(1);
    idx              = (PW + 1)'(pos) - (PW + 1)'(1);
    pos_next         = pos;
    high_nibble_next = high_nibble;
    digit_fault_next = digit_fault;
    etx_seen_next    = etx_seen;
    bank_next        = bank;
    push             = 1'b0;
    push_cmd         = '{kind: CMD_BAD_FRAME, bank: bank};
    wr_en            = 1'b0;
    wr_addr          = {bank, idx[WIDX_W+1:2]};
    wr_lane          = idx[1];
    wr_data          = {high_nibble, dig.val};
    if (accept) begin
      if (pos == '0) begin
        // hunting for a frame
        if (rx_byte == STX_CHAR) begin
          pos_next         = PW'(1);
          high_nibble_next = 4'h0;
          digit_fault_next = 1'b0;
          etx_seen_next    = 1'b0;
        end else if (rx_byte == ERR_CHAR) begin
          push          = 1'b1;
          push_cmd.kind = CMD_ERR_REPLY;
        end
      end else begin
        if (idx < four_n) begin
          if (dig.bad) begin
            digit_fault_next = 1'b1;
          end
          if (!idx[0]) begin
            high_nibble_next = dig.val;
          end else begin
            wr_en = 1'b1;
          end
        end else if (idx == four_n) begin
          etx_seen_next = (rx_byte == ETX_CHAR);
        end
        // frame end after the two checksum characters
        if (pos_inc >= lim) begin
          pos_next = '0;
          push     = 1'b1;
          if (etx_seen_next && !digit_fault_next) begin
            push_cmd.kind = CMD_WORDS;
            bank_next     = !bank;
          end else begin
            push_cmd.kind = CMD_BAD_FRAME;
          end
        end else begin
          pos_next = pos_inc[PW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      high_nibble <= 4'h0;
      digit_fault <= 1'b0;
      etx_seen    <= 1'b0;
      bank        <= 1'b0;
    end else begin
      pos         <= pos_next;
      high_nibble <= high_nibble_next;
      digit_fault <= digit_fault_next;
      etx_seen    <= etx_seen_next;
      bank        <= bank_next;
    end
  end

  `HEXRD_ASSERT_IMPL(a_push_not_full, push, !q_full, "command pushed into a full queue")
  `HEXRD_ASSERT_IMPL(a_write_in_frame, wr_en, pos != '0, "buffer written outside a frame")

endmodule

@@ sv/hexrd_queue.sv @@
// Two-entry command queue between the front end and the result sequencer.
// Uses hexrd_pkg for the command type.
`include "hex_ascii_read_reply_parser_defines.svh"

module hexrd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hexrd_pkg::cmd_t push_cmd,
  output logic            full,
  output logic            head_valid,
  output hexrd_pkg::cmd_t head_cmd,
  input  logic            pop
);
  import hexrd_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entry[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `HEXRD_ASSERT_ALWAYS(a_count_bound, count != 2'd3, "queue fill level out of range")
  `HEXRD_ASSERT_IMPL(a_pop_not_empty, pop, head_valid, "pop from an empty queue")

endmodule

@@ sv/hexrd_back.sv @@
// Result sequencer: turns queued commands into result beats.
// Uses hexrd_pkg; reads decoded words from hexrd_buf.
`include "hex_ascii_read_reply_parser_defines.svh"

module hexrd_back #(
  parameter  int MAX_WORDS = 16,
  localparam int NW        = $clog2(MAX_WORDS + 1),
  localparam int WIDX_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  hexrd_pkg::cmd_t head_cmd,
  output logic            pop,
  input  logic [NW-1:0]   n_use,
  input  logic [15:0]     start_address,
  input  logic [7:0]      data_type,
  output logic            rd_en,
  output logic [WIDX_W:0] rd_addr,
  input  logic [15:0]     rd_data,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [15:0]     word_value,
  output logic [15:0]     word_address,
  output logic [7:0]      type_tag,
  output logic [1:0]      status,
  output logic            last
);
  import hexrd_pkg::*;

  back_state_t   state, state_next;
  logic [NW-1:0] word_idx, rd_idx;
  logic          load_word, load_err, advance;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          state_next = (head_cmd.kind == CMD_WORDS) ? BK_FETCH : BK_SEND;
        end
      end
      BK_FETCH: state_next = BK_SEND;
      BK_SEND: begin
        if (!out_stall) begin
          state_next = last ? BK_IDLE : BK_FETCH;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    rd_en     = 1'b0;
    rd_idx    = word_idx + NW'(1);
    pop       = 1'b0;
    load_word = 1'b0;
    load_err  = 1'b0;
    advance   = 1'b0;
    out_valid = 1'b0;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          if (head_cmd.kind == CMD_WORDS) begin
            rd_en  = 1'b1;
            rd_idx = '0;
          end else begin
            load_err = 1'b1;
          end
        end
      end
      BK_FETCH: load_word = 1'b1;
      BK_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (last) begin
            pop = 1'b1;
          end else begin
            rd_en   = 1'b1;
            advance = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign rd_addr = {head_cmd.bank, rd_idx[WIDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      word_idx <= '0;
    end else begin
      state <= state_next;
      if (state == BK_IDLE) begin
        word_idx <= '0;
      end else if (advance) begin
        word_idx <= word_idx + NW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_err) begin
      word_value   <= 16'h0000;
      word_address <= start_address;
      type_tag     <= data_type;
      status       <= (head_cmd.kind == CMD_ERR_REPLY) ? ST_DEV_ERR : ST_BAD_FRAME;
      last         <= 1'b1;
    end else if (load_word) begin
      word_value   <= rd_data;
      word_address <= start_address + 16'(word_idx);
      type_tag     <= data_type;
      status       <= ST_WORD;
      last         <= (word_idx + NW'(1) == n_use);
    end
  end

  `HEXRD_ASSERT_IMPL(a_fetch_after_read, state == BK_FETCH, $past(rd_en), "fetch without read")
  `HEXRD_ASSERT_IMPL(a_busy_has_cmd, state != BK_IDLE, head_valid, "busy with no command")

endmodule
